### rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared widths, defaults and the per-atom tag for the point-charge
// potential summation pipeline.
// ----------------------------------------------------------------------------
package pcp_pkg;

   localparam int COORD_W       = 32;
   localparam int CHARGE_W      = 16;
   localparam int POT_W         = 48;
   localparam int COUNT_W       = 7;
   localparam int INDEX_W       = 6;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int HALF_LO_W     = 17;
   localparam int HALF_HI_W     = DIFF_W - HALF_LO_W;
   localparam int R2_W          = 2 * DIFF_W;
   localparam int ROOT_W        = R2_W / 2 + 1;
   localparam int DIV_SHIFT     = 32;
   localparam int NUM_W         = CHARGE_W + DIV_SHIFT;
   localparam int MAX_ATOMS_DEF = 64;
   localparam int DIM_DEF       = 3;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Control bundle that travels with every atom through the pipeline
   typedef struct packed {
      logic                last;
      logic                skip;
      logic                neg;
      logic [CHARGE_W-1:0] mag;
   } pcp_tag_type;

endpackage

### rtl/pcp_seq.sv
// ----------------------------------------------------------------------------
// pcp_seq
// Command intake, atom table and atom issue sequencer. Loads write the
// table; a query streams the first min(atom_count, MAX_ATOMS) entries, one per cycle.
// ----------------------------------------------------------------------------
module pcp_seq #(
   parameter int MAX_ATOMS = pcp_pkg::MAX_ATOMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [pcp_pkg::INDEX_W-1:0]   req_atom_index,
   input  logic signed [pcp_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [pcp_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [pcp_pkg::COORD_W-1:0]  req_coord_z,
   input  logic signed [pcp_pkg::CHARGE_W-1:0] req_charge,
   input  logic                          csr_wr_en,
   input  logic [pcp_pkg::COUNT_W-1:0]   csr_wr_data,
   input  logic                          done,
   output logic                          atom_vld,
   output pcp_pkg::pcp_tag_type          atom_tag,
   output logic signed [pcp_pkg::COORD_W-1:0]  pt_x,
   output logic signed [pcp_pkg::COORD_W-1:0]  pt_y,
   output logic signed [pcp_pkg::COORD_W-1:0]  pt_z,
   output logic signed [pcp_pkg::COORD_W-1:0]  atom_x,
   output logic signed [pcp_pkg::COORD_W-1:0]  atom_y,
   output logic signed [pcp_pkg::COORD_W-1:0]  atom_z
);
   import pcp_pkg::*;

   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int IW = (INDEX_W > CW) ? INDEX_W : CW;
   localparam int NW = (COUNT_W > CW) ? COUNT_W : CW;

   logic signed [COORD_W-1:0]  mem_x [0:MAX_ATOMS-1];
   logic signed [COORD_W-1:0]  mem_y [0:MAX_ATOMS-1];
   logic signed [COORD_W-1:0]  mem_z [0:MAX_ATOMS-1];
   logic signed [CHARGE_W-1:0] mem_q [0:MAX_ATOMS-1];

   logic [COUNT_W-1:0] count_ff;
   logic               busy_ff;
   logic               issue_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      n_ff;
   logic [CW-1:0]      n_in;
   logic               vld_ff;
   logic               last_ff;
   logic               skip_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [COORD_W-1:0] rx_ff, ry_ff, rz_ff;
   logic signed [CHARGE_W-1:0] rq_ff;
   logic               accept;
   logic               load_ok;
   logic               issue_last;
   logic [AW-1:0]      wr_addr;

   assign accept     = start && !busy_ff;
   assign load_ok    = IW'(req_atom_index) < IW'(MAX_ATOMS);
   assign wr_addr    = AW'(req_atom_index);
   assign issue_last = (n_ff == '0) || (CW'(cnt_ff + 1'b1) >= n_ff);
   assign n_in       = (NW'(count_ff) > NW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(count_ff);

   // Hold the configured atom count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Write the table on a load transfer
   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_LOAD && load_ok) begin
         mem_x[wr_addr] <= req_coord_x;
         mem_y[wr_addr] <= req_coord_y;
         mem_z[wr_addr] <= req_coord_z;
         mem_q[wr_addr] <= req_charge;
      end
   end

   // Read the table at the issue counter
   always_ff @(posedge clock) begin
      rx_ff <= mem_x[cnt_ff[AW-1:0]];
      ry_ff <= mem_y[cnt_ff[AW-1:0]];
      rz_ff <= mem_z[cnt_ff[AW-1:0]];
      rq_ff <= mem_q[cnt_ff[AW-1:0]];
   end

   // Latch the query point
   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_QUERY) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
         pz_ff <= req_coord_z;
         n_ff  <= n_in;
      end
   end

   // Sequence the query: issue atoms, then wait for the sum
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         issue_ff <= 1'b0;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
         last_ff  <= 1'b0;
         skip_ff  <= 1'b0;
      end else begin
         vld_ff <= issue_ff;
         if (accept && req_func == FUNC_QUERY) begin
            busy_ff  <= 1'b1;
            issue_ff <= 1'b1;
            cnt_ff   <= '0;
         end else begin
            if (issue_ff) begin
               last_ff <= issue_last;
               skip_ff <= (n_ff == '0);
               cnt_ff  <= CW'(cnt_ff + 1'b1);
               if (issue_last) begin
                  issue_ff <= 1'b0;
               end
            end
            if (done) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign busy          = busy_ff;
   assign atom_vld      = vld_ff;
   assign atom_tag.last = last_ff;
   assign atom_tag.skip = skip_ff;
   assign atom_tag.neg  = rq_ff[CHARGE_W-1];
   assign atom_tag.mag  = rq_ff[CHARGE_W-1] ? CHARGE_W'(-rq_ff) : CHARGE_W'(rq_ff);
   assign pt_x   = px_ff;
   assign pt_y   = py_ff;
   assign pt_z   = pz_ff;
   assign atom_x = rx_ff;
   assign atom_y = ry_ff;
   assign atom_z = rz_ff;

   // Issue only while busy; a query always ends its issue with a last atom
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> busy_ff) else $error("atom issued while idle");
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      issue_ff && issue_last && !(accept) |=> !issue_ff)
      else $error("issue continued past last atom");

endmodule

### rtl/pcp_dist.sv
// ----------------------------------------------------------------------------
// pcp_dist
// Squared distance in four stages: differences, split partial products,
// per-axis squares, sum over the axes in use.
// ----------------------------------------------------------------------------
module pcp_dist #(
   parameter int DIM = pcp_pkg::DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_vld,
   input  pcp_pkg::pcp_tag_type               in_tag,
   input  logic signed [pcp_pkg::COORD_W-1:0] pt_x,
   input  logic signed [pcp_pkg::COORD_W-1:0] pt_y,
   input  logic signed [pcp_pkg::COORD_W-1:0] pt_z,
   input  logic signed [pcp_pkg::COORD_W-1:0] atom_x,
   input  logic signed [pcp_pkg::COORD_W-1:0] atom_y,
   input  logic signed [pcp_pkg::COORD_W-1:0] atom_z,
   output logic                               out_vld,
   output pcp_pkg::pcp_tag_type               out_tag,
   output logic [pcp_pkg::R2_W-1:0]           out_r2
);
   import pcp_pkg::*;

   logic signed [DIFF_W-1:0] diff [0:2];
   logic [DIFF_W-1:0]        d_ff [0:2];
   logic [2*HALF_HI_W-1:0]   hh_ff [0:2];
   logic [HALF_HI_W+HALF_LO_W-1:0] hl_ff [0:2];
   logic [2*HALF_LO_W-1:0]   ll_ff [0:2];
   logic [R2_W-1:0]          sq_ff [0:2];
   logic [R2_W-1:0]          r2_ff;
   logic [R2_W-1:0]          r2_in;
   logic                     v_ff [0:3];
   pcp_tag_type              t_ff [0:3];
   pcp_tag_type              t3_in;

   assign diff[0] = DIFF_W'(pt_x) - DIFF_W'(atom_x);
   assign diff[1] = DIFF_W'(pt_y) - DIFF_W'(atom_y);
   assign diff[2] = DIFF_W'(pt_z) - DIFF_W'(atom_z);

   // Per axis: magnitude, partial products, square
   for (genvar j = 0; j < 3; j++) begin : g_axis
      always_ff @(posedge clock) begin
         d_ff[j]  <= diff[j][DIFF_W-1] ? DIFF_W'(-diff[j]) : DIFF_W'(diff[j]);
         hh_ff[j] <= d_ff[j][DIFF_W-1 -: HALF_HI_W] * d_ff[j][DIFF_W-1 -: HALF_HI_W];
         hl_ff[j] <= d_ff[j][DIFF_W-1 -: HALF_HI_W] * d_ff[j][HALF_LO_W-1:0];
         ll_ff[j] <= d_ff[j][HALF_LO_W-1:0] * d_ff[j][HALF_LO_W-1:0];
         sq_ff[j] <= (R2_W'(hh_ff[j]) << (2 * HALF_LO_W))
                   + (R2_W'(hl_ff[j]) << (HALF_LO_W + 1))
                   + R2_W'(ll_ff[j]);
      end
   end

   // Sum the axes in use
   always_comb begin
      r2_in = '0;
      for (int j = 0; j < DIM; j++) begin
         r2_in = r2_in + sq_ff[j];
      end
   end

   // Mark a coincident atom as skipped
   always_comb begin
      t3_in      = t_ff[2];
      t3_in.skip = t_ff[2].skip || (r2_in == '0);
   end

   always_ff @(posedge clock) begin
      r2_ff <= r2_in;
      t_ff[0] <= in_tag;
      t_ff[1] <= t_ff[0];
      t_ff[2] <= t_ff[1];
      t_ff[3] <= t3_in;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
         v_ff[1] <= 1'b0;
         v_ff[2] <= 1'b0;
         v_ff[3] <= 1'b0;
      end else begin
         v_ff[0] <= in_vld;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
      end
   end

   assign out_vld = v_ff[3];
   assign out_tag = t_ff[3];
   assign out_r2  = r2_ff;

endmodule

### rtl/pcp_sqrt.sv
// ----------------------------------------------------------------------------
// pcp_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pcp_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  pcp_pkg::pcp_tag_type        in_tag,
   input  logic [pcp_pkg::R2_W-1:0]    in_r2,
   output logic                        out_vld,
   output pcp_pkg::pcp_tag_type        out_tag,
   output logic [pcp_pkg::ROOT_W-1:0]  out_root
);
   import pcp_pkg::*;

   localparam int STEPS = ROOT_W;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_ff  [0:STEPS-1];
   logic [ROOT_W-1:0] root_ff [0:STEPS-1];
   logic [REM_W-1:0]  rem_ff  [0:STEPS-1];
   logic              vld_ff  [0:STEPS-1];
   pcp_tag_type       tag_ff  [0:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [RAD_W-1:0]  rad_c;
      logic [ROOT_W-1:0] root_c;
      logic [REM_W-1:0]  rem_c;
      logic              vld_c;
      pcp_tag_type       tag_c;
      logic [REM_W+1:0]  sh;
      logic [REM_W+1:0]  trial;
      logic              fit;

      if (k == 0) begin : g_first
         assign rad_c  = RAD_W'(in_r2);
         assign root_c = '0;
         assign rem_c  = '0;
         assign vld_c  = in_vld;
         assign tag_c  = in_tag;
      end else begin : g_next
         assign rad_c  = rad_ff[k-1];
         assign root_c = root_ff[k-1];
         assign rem_c  = rem_ff[k-1];
         assign vld_c  = vld_ff[k-1];
         assign tag_c  = tag_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit
      assign sh    = {rem_c, rad_c[RAD_W-1 -: 2]};
      assign trial = (REM_W + 2)'({root_c, 2'b01});
      assign fit   = sh >= trial;

      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_c << 2;
         root_ff[k] <= {root_c[ROOT_W-2:0], fit};
         rem_ff[k]  <= fit ? REM_W'(sh - trial) : REM_W'(sh);
         tag_ff[k]  <= tag_c;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_c;
         end
      end
   end

   assign out_vld  = vld_ff[STEPS-1];
   assign out_tag  = tag_ff[STEPS-1];
   assign out_root = root_ff[STEPS-1];

endmodule

### rtl/pcp_div.sv
// ----------------------------------------------------------------------------
// pcp_div
// Pipelined restoring divider: |charge| * 2^32 / root, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module pcp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  pcp_pkg::pcp_tag_type        in_tag,
   input  logic [pcp_pkg::ROOT_W-1:0]  in_root,
   output logic                        out_vld,
   output pcp_pkg::pcp_tag_type        out_tag,
   output logic [pcp_pkg::NUM_W-1:0]   out_quot
);
   import pcp_pkg::*;

   localparam int STEPS = NUM_W;

   logic [NUM_W-1:0]  num_ff  [0:STEPS-1];
   logic [NUM_W-1:0]  quot_ff [0:STEPS-1];
   logic [ROOT_W-1:0] rem_ff  [0:STEPS-1];
   logic [ROOT_W-1:0] root_ff [0:STEPS-1];
   logic              vld_ff  [0:STEPS-1];
   pcp_tag_type       tag_ff  [0:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [NUM_W-1:0]  num_c;
      logic [NUM_W-1:0]  quot_c;
      logic [ROOT_W-1:0] rem_c;
      logic [ROOT_W-1:0] root_c;
      logic              vld_c;
      pcp_tag_type       tag_c;
      logic [ROOT_W:0]   sh;
      logic              fit;

      if (k == 0) begin : g_first
         assign num_c  = {in_tag.mag, {DIV_SHIFT{1'b0}}};
         assign quot_c = '0;
         assign rem_c  = '0;
         assign root_c = in_root;
         assign vld_c  = in_vld;
         assign tag_c  = in_tag;
      end else begin : g_next
         assign num_c  = num_ff[k-1];
         assign quot_c = quot_ff[k-1];
         assign rem_c  = rem_ff[k-1];
         assign root_c = root_ff[k-1];
         assign vld_c  = vld_ff[k-1];
         assign tag_c  = tag_ff[k-1];
      end

      // Shift in one dividend bit, subtract when the divisor fits
      assign sh  = {rem_c, num_c[NUM_W-1]};
      assign fit = sh >= {1'b0, root_c};

      always_ff @(posedge clock) begin
         num_ff[k]  <= num_c << 1;
         quot_ff[k] <= {quot_c[NUM_W-2:0], fit};
         rem_ff[k]  <= fit ? ROOT_W'(sh - {1'b0, root_c}) : ROOT_W'(sh);
         root_ff[k] <= root_c;
         tag_ff[k]  <= tag_c;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_c;
         end
      end
   end

   assign out_vld  = vld_ff[STEPS-1];
   assign out_tag  = tag_ff[STEPS-1];
   assign out_quot = quot_ff[STEPS-1];

endmodule

### rtl/pcp_acc.sv
// ----------------------------------------------------------------------------
// pcp_acc
// Signed accumulation of the per-atom terms and final clipping to Q16.32.
// ----------------------------------------------------------------------------
module pcp_acc #(
   parameter int MAX_ATOMS = pcp_pkg::MAX_ATOMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_vld,
   input  pcp_pkg::pcp_tag_type               in_tag,
   input  logic [pcp_pkg::NUM_W-1:0]          in_quot,
   output logic                               done,
   output logic                               rsp_valid,
   output logic signed [pcp_pkg::POT_W-1:0]   rsp_potential,
   output logic                               rsp_saturated
);
   import pcp_pkg::*;

   localparam int ACC_W = POT_W + $clog2(MAX_ATOMS + 1) + 1;
   localparam logic signed [ACC_W-1:0] POT_HI = ACC_W'({1'b0, {(POT_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] POT_LO = -POT_HI - ACC_W'(1);

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] term;
   logic                    fin_ff;
   logic                    valid_ff;
   logic signed [POT_W-1:0] pot_ff;
   logic                    sat_ff;

   assign term = $signed(ACC_W'(in_quot));

   // Add or subtract one term
   always_comb begin
      acc_in = acc_ff;
      if (fin_ff) begin
         acc_in = '0;
      end else if (in_vld && !in_tag.skip) begin
         acc_in = in_tag.neg ? acc_ff - term : acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         fin_ff   <= in_vld && in_tag.last;
         valid_ff <= fin_ff;
      end
   end

   // Clip the total and drive the result
   always_ff @(posedge clock) begin
      if (fin_ff) begin
         if (acc_ff > POT_HI) begin
            pot_ff <= POT_HI[POT_W-1:0];
            sat_ff <= 1'b1;
         end else if (acc_ff < POT_LO) begin
            pot_ff <= POT_LO[POT_W-1:0];
            sat_ff <= 1'b1;
         end else begin
            pot_ff <= acc_ff[POT_W-1:0];
            sat_ff <= 1'b0;
         end
      end
   end

   assign done          = fin_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_potential = pot_ff;
   assign rsp_saturated = sat_ff;

   // Accumulator is clear once a result goes out
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> acc_ff == '0) else $error("accumulator not cleared");

endmodule

### rtl/point_charge_potential_sum.sv
// ----------------------------------------------------------------------------
// point_charge_potential_sum
// Sums charge over distance from a query point across a table of atoms.
// A load writes the table; a query streams its atoms through table read,
// distance, square root, divide, then sum and clip, and strobes its result
// after the last atom. Loads are taken back to back; a query holds busy
// until its sum is done, so the next transfer waits for it.
// Reset clears atom_count and control; the table is undefined until loaded.
// The receiver cannot stall: rsp_valid marks a one-cycle result.
// ----------------------------------------------------------------------------
module point_charge_potential_sum #(
   parameter int MAX_ATOMS = pcp_pkg::MAX_ATOMS_DEF,
   parameter int DIM       = pcp_pkg::DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [pcp_pkg::INDEX_W-1:0]         req_atom_index,
   input  logic signed [pcp_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [pcp_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [pcp_pkg::COORD_W-1:0]  req_coord_z,
   input  logic signed [pcp_pkg::CHARGE_W-1:0] req_charge,
   input  logic                                csr_wr_en,
   input  logic [pcp_pkg::COUNT_W-1:0]         csr_wr_data,
   output logic                                rsp_valid,
   output logic signed [pcp_pkg::POT_W-1:0]    rsp_potential,
   output logic                                rsp_saturated
);
   import pcp_pkg::*;

   logic                       a_vld, d_vld, s_vld, q_vld, done;
   pcp_tag_type                a_tag, d_tag, s_tag, q_tag;
   logic signed [COORD_W-1:0]  pt_x, pt_y, pt_z, atom_x, atom_y, atom_z;
   logic [R2_W-1:0]            r2;
   logic [ROOT_W-1:0]          root;
   logic [NUM_W-1:0]           quot;

   pcp_seq #(.MAX_ATOMS(MAX_ATOMS)) u_seq (
      .clock, .reset, .start, .busy, .req_func, .req_atom_index,
      .req_coord_x, .req_coord_y, .req_coord_z, .req_charge,
      .csr_wr_en, .csr_wr_data, .done,
      .atom_vld(a_vld), .atom_tag(a_tag),
      .pt_x, .pt_y, .pt_z, .atom_x, .atom_y, .atom_z
   );

   pcp_dist #(.DIM(DIM)) u_dist (
      .clock, .reset, .in_vld(a_vld), .in_tag(a_tag),
      .pt_x, .pt_y, .pt_z, .atom_x, .atom_y, .atom_z,
      .out_vld(d_vld), .out_tag(d_tag), .out_r2(r2)
   );

   pcp_sqrt u_sqrt (
      .clock, .reset, .in_vld(d_vld), .in_tag(d_tag), .in_r2(r2),
      .out_vld(s_vld), .out_tag(s_tag), .out_root(root)
   );

   pcp_div u_div (
      .clock, .reset, .in_vld(s_vld), .in_tag(s_tag), .in_root(root),
      .out_vld(q_vld), .out_tag(q_tag), .out_quot(quot)
   );

   pcp_acc #(.MAX_ATOMS(MAX_ATOMS)) u_acc (
      .clock, .reset, .in_vld(q_vld), .in_tag(q_tag), .in_quot(quot),
      .done, .rsp_valid, .rsp_potential, .rsp_saturated
   );

   // A result only closes a query; queries hold busy, loads do not
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without query");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_QUERY |=> busy)
      else $error("query transfer did not raise busy");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_LOAD |=> !busy && !rsp_valid)
      else $error("load transfer started work");

endmodule

### tb/sv/point_charge_potential_sum_tb.sv
// ----------------------------------------------------------------------------
// point_charge_potential_sum_tb
// Self-checking bench for the point-charge potential sum. Loads atoms into
// the table, runs queries under several atom_count settings, and checks
// every potential and saturation flag against a bit-exact predictor.
// ----------------------------------------------------------------------------
module point_charge_potential_sum_tb;
   import pcp_pkg::*;

   localparam int  NUM_SLOTS = 64;
   localparam int  ITEM_GOAL = 800;
   localparam int  DRAIN_CYC = 200;
   localparam longint POT_HI = (64'sd1 <<< 47) - 1;
   localparam longint POT_LO = -(64'sd1 <<< 47);

   typedef struct {
      logic                       func;
      logic [INDEX_W-1:0]         slot;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic signed [CHARGE_W-1:0] q;
   } atom_req_type;

   typedef struct {
      logic signed [POT_W-1:0] potential;
      logic                    saturated;
   } potential_type;

   // Tracks the table and count, predicts each query, matches responses
   class potential_scoreboard;
      logic signed [COORD_W-1:0]  tab_x [NUM_SLOTS];
      logic signed [COORD_W-1:0]  tab_y [NUM_SLOTS];
      logic signed [COORD_W-1:0]  tab_z [NUM_SLOTS];
      logic signed [CHARGE_W-1:0] tab_q [NUM_SLOTS];
      int unsigned atom_count = 0;
      potential_type pending_q[$];
      int unsigned mismatches = 0;
      int unsigned matched = 0;
      int unsigned sat_seen = 0;

      function potential_type sum_potential(atom_req_type r);
         potential_type res;
         int n;
         int qi;
         longint acc;
         longint num;
         longint term;
         logic signed [DIFF_W-1:0] dx, dy, dz;
         logic [DIFF_W-1:0] ax, ay, az;
         logic [67:0] r2, sq;
         logic [33:0] root, cand;
         n = (atom_count > NUM_SLOTS) ? NUM_SLOTS : atom_count;
         acc = 0;
         for (int i = 0; i < n; i++) begin
            dx = {r.x[COORD_W-1], r.x} - {tab_x[i][COORD_W-1], tab_x[i]};
            dy = {r.y[COORD_W-1], r.y} - {tab_y[i][COORD_W-1], tab_y[i]};
            dz = {r.z[COORD_W-1], r.z} - {tab_z[i][COORD_W-1], tab_z[i]};
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            az = (dz < 0) ? -dz : dz;
            r2 = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay) + 68'(az) * 68'(az);
            // skip an atom sitting exactly on the point
            if (r2 == 0) continue;
            root = '0;
            for (int b = 33; b >= 0; b--) begin
               cand = root | (34'd1 << b);
               sq = 68'(cand) * 68'(cand);
               if (sq <= r2) root = cand;
            end
            qi = tab_q[i];
            num = longint'((qi < 0) ? -qi : qi) << DIV_SHIFT;
            term = num / longint'({30'd0, root});
            if (qi < 0) acc -= term;
            else acc += term;
         end
         res.saturated = 1'b0;
         if (acc > POT_HI) begin
            acc = POT_HI;
            res.saturated = 1'b1;
         end else if (acc < POT_LO) begin
            acc = POT_LO;
            res.saturated = 1'b1;
         end
         res.potential = acc[POT_W-1:0];
         return res;
      endfunction

      function void note_transfer(atom_req_type r);
         if (r.func == FUNC_LOAD) begin
            tab_x[r.slot] = r.x;
            tab_y[r.slot] = r.y;
            tab_z[r.slot] = r.z;
            tab_q[r.slot] = r.q;
         end else begin
            pending_q.push_back(sum_potential(r));
         end
      endfunction

      function void check_result(logic signed [POT_W-1:0] pot, logic sat);
         potential_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result potential=%0d sat=%0b", pot, sat);
            return;
         end
         e = pending_q.pop_front();
         if (pot !== e.potential || sat !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: potential exp=%0d act=%0d, saturated exp=%0b act=%0b",
                        e.potential, pot, e.saturated, sat);
         end else begin
            matched++;
            if (sat) sat_seen++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_func = FUNC_LOAD;
   logic [INDEX_W-1:0]         req_atom_index = '0;
   logic signed [COORD_W-1:0]  req_coord_x = '0;
   logic signed [COORD_W-1:0]  req_coord_y = '0;
   logic signed [COORD_W-1:0]  req_coord_z = '0;
   logic signed [CHARGE_W-1:0] req_charge = '0;
   logic                       csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]         csr_wr_data = '0;
   logic                       rsp_valid;
   logic signed [POT_W-1:0]    rsp_potential;
   logic                       rsp_saturated;

   potential_scoreboard sb = new();
   bit          loaded [NUM_SLOTS];
   int unsigned sent = 0;
   int unsigned queries = 0;
   bit          calm = 1'b0;

   point_charge_potential_sum uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_atom_index (req_atom_index),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_charge     (req_charge),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_potential  (rsp_potential),
      .rsp_saturated  (rsp_saturated)
   );

   always #1 clock = ~clock;

   // check every strobed result at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_potential, rsp_saturated);
   end

   // drive one transfer, optionally after an idle burst
   task automatic send_item(atom_req_type r);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start          = 1'b1;
      req_func       = r.func;
      req_atom_index = r.slot;
      req_coord_x    = r.x;
      req_coord_y    = r.y;
      req_coord_z    = r.z;
      req_charge     = r.q;
      do @(posedge clock); while (busy);
      sb.note_transfer(r);
      sent++;
      if (r.func == FUNC_QUERY) queries++;
      else loaded[r.slot] = 1'b1;
   endtask

   task automatic load_atom(int slot, int x, int y, int z, int q);
      atom_req_type r;
      r.func = FUNC_LOAD;
      r.slot = INDEX_W'(slot);
      r.x = x; r.y = y; r.z = z; r.q = CHARGE_W'(q);
      send_item(r);
   endtask

   task automatic query_at(int x, int y, int z);
      atom_req_type r;
      r.func = FUNC_QUERY;
      r.slot = INDEX_W'($urandom);
      r.x = x; r.y = y; r.z = z; r.q = CHARGE_W'($urandom);
      send_item(r);
   endtask

   // drop start, drain, let the block settle, then write atom_count
   task automatic write_count(int unsigned n);
      @(negedge clock);
      start = 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start       = 1'b0;
      csr_wr_en   = 1'b1;
      csr_wr_data = COUNT_W'(n);
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.atom_count = n;
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 2))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
         default: return $signed($urandom_range(0, 16)) - 8;
      endcase
   endfunction

   function automatic int rand_charge();
      case ($urandom_range(0, 4))
         0: return 32767;
         1: return -32768;
         default: return $signed($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // load every slot that the current count will read
   task automatic fill_table(int unsigned n);
      int lim;
      lim = (n > NUM_SLOTS) ? NUM_SLOTS : n;
      for (int i = 0; i < lim; i++)
         if (!loaded[i]) load_atom(i, rand_coord(), rand_coord(), rand_coord(), rand_charge());
   endtask

   // random mix of loads and queries; queries often land on or near atoms
   task automatic random_items(int unsigned n_items);
      int s, ox, oy, oz;
      for (int k = 0; k < n_items; k++) begin
         if (sent > ITEM_GOAL - 150) calm = 1'b1;
         if ($urandom_range(0, 9) < 4) begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            if (loaded[s] && $urandom_range(0, 1))
               load_atom(s, sb.tab_x[s] + $signed($urandom_range(0, 8)) - 4,
                         sb.tab_y[s] + $signed($urandom_range(0, 8)) - 4,
                         rand_coord(), rand_charge());
            else
               load_atom(s, rand_coord(), rand_coord(), rand_coord(), rand_charge());
         end else begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            if (!loaded[s]) s = 0;
            ox = 0; oy = 0; oz = 0;
            case ($urandom_range(0, 2))
               0: ;
               1: begin
                  ox = $signed($urandom_range(0, 6)) - 3;
                  oy = $signed($urandom_range(0, 6)) - 3;
                  oz = $signed($urandom_range(0, 6)) - 3;
               end
               default: begin
                  ox = rand_coord();
                  oy = rand_coord();
                  oz = rand_coord();
               end
            endcase
            if (loaded[s])
               query_at(sb.tab_x[s] + ox, sb.tab_y[s] + oy, sb.tab_z[s] + oz);
            else
               query_at(rand_coord(), rand_coord(), rand_coord());
         end
      end
   endtask

   initial begin
      int unsigned counts [10] = '{64, 1, 8, 127, 3, 64, 20, 100, 5, 64};
      int unsigned waited;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty sum at reset count
      query_at(0, 0, 0);
      query_at(32'h7fffffff, 32'h80000000, 1);
      // extreme atoms
      load_atom(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32767);
      load_atom(1, 32'h80000000, 32'h80000000, 32'h80000000, -32768);
      load_atom(2, 0, 1, 0, 32767);
      load_atom(3, 1, 0, 0, 32767);
      write_count(1);
      query_at(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      query_at(32'h7ffffffe, 32'h7fffffff, 32'h7fffffff);
      query_at(32'h80000000, 32'h80000000, 32'h80000000);
      write_count(4);
      // two atoms one LSB away drive the sum past the top
      query_at(0, 0, 0);
      query_at(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      load_atom(2, 0, 1, 0, -32768);
      load_atom(3, 1, 0, 0, -32768);
      query_at(0, 0, 0);
      query_at(0, 1, 0);
      load_atom(2, 0, 0, 0, 0);
      query_at(5, -7, 3);
      write_count(0);
      query_at(-1, -1, -1);

      foreach (counts[p]) begin
         write_count(counts[p]);
         fill_table(counts[p]);
         random_items((ITEM_GOAL - 20) / $size(counts));
      end

      @(negedge clock);
      start = 1'b0;
      waited = 0;
      while (sb.pending_q.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYC) @(posedge clock);
      $display("Sent %0d transfers (%0d queries) over %0d count settings including 0, 64, 127.",
               sent, queries, $size(counts) + 4);
      $display("Matched %0d potentials, %0d saturated; %0d mismatches, %0d left over.",
               sb.matched, sb.sat_seen, sb.mismatches, sb.pending_q.size());
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("point_charge_potential_sum verification clean");
      else
         $display("point_charge_potential_sum verification failed");
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #2000000;
      $display("point_charge_potential_sum verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/pcp_pkg.sv
rtl/pcp_seq.sv
rtl/pcp_dist.sv
rtl/pcp_sqrt.sv
rtl/pcp_div.sv
rtl/pcp_acc.sv
rtl/point_charge_potential_sum.sv
tb/sv/point_charge_potential_sum_tb.sv
